### rtl/mf2i_pkg.sv
// Shared types, constants and byte forming for the meter float converter.
`default_nettype none

package mf2i_pkg;

    localparam int unsigned MANT_W = 23;

    localparam logic [7:0] C_ASCII_ZERO = 8'h30;
    // 0x7F - 0x40: bias of the meter exponent relative to IEEE single
    localparam logic [7:0] C_EXP_OFFSET = 8'h3F;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_HOLD
    } t_state;

    function automatic logic [7:0] pair_to_byte(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] h;
        logic [7:0] l;
        begin
            h = hi - C_ASCII_ZERO;
            l = lo - C_ASCII_ZERO;
            pair_to_byte = {h[3:0], 4'b0000} | l;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/meter_float_to_ieee_single.sv
// Meter float to IEEE single converter, top level.
`default_nettype none

// Converts one meter float, given as eight ASCII-coded characters, into an
// IEEE-754 single precision bit pattern. Character pairs form bytes: the
// first byte carries the sign and a 7-bit meter exponent, the rest the
// mantissa (16 bits in the short form, 24 bits with the lowest dropped in
// the long form). A zero mantissa yields 0. The mantissa is normalized by a
// shift register that moves one bit per cycle; the number of normalize
// shifts is 0..15 in the short form and 0..22 in the long form. The input
// is taken only while the converter is idle; a finished result sits in an
// output register, so a new request may be accepted while it waits. The
// exponent wraps modulo 256 with no saturation.
module meter_float_to_ieee_single
    import mf2i_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_char0,
    input  wire logic [7:0]  i_char1,
    input  wire logic [7:0]  i_char2,
    input  wire logic [7:0]  i_char3,
    input  wire logic [7:0]  i_char4,
    input  wire logic [7:0]  i_char5,
    input  wire logic [7:0]  i_char6,
    input  wire logic [7:0]  i_char7,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_ieee_bits
);

    t_state              r_state;
    t_state              n_state;
    logic [MANT_W-1:0]   r_mant;
    logic [MANT_W-1:0]   n_mant;
    logic [7:0]          r_exp;
    logic [7:0]          n_exp;
    logic                r_sign;
    logic                n_sign;
    logic                r_zero;
    logic                n_zero;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [31:0]         r_out_bits;
    logic [31:0]         n_out_bits;

    logic [7:0]          w_b0;
    logic [7:0]          w_b1;
    logic [7:0]          w_b2;
    logic [7:0]          w_b3;
    logic [MANT_W-1:0]   w_load_mant;
    logic                w_accept;
    logic                w_norm_done;
    logic                w_out_free;
    logic                w_write_out;
    logic [7:0]          w_exp_final;
    logic [31:0]         w_packed;

    // Byte forming of the incoming request
    assign w_b0 = pair_to_byte(i_char0, i_char1);
    assign w_b1 = pair_to_byte(i_char2, i_char3);
    assign w_b2 = pair_to_byte(i_char4, i_char5);
    assign w_b3 = pair_to_byte(i_char6, i_char7);

    // Align both forms so that the normalized top bit sits at the register's MSB;
    // the short form's 16 bits land above 7 zero bits.
    always_comb begin
        logic [23:0] v_long;
        v_long = {w_b1, w_b2, w_b3};
        if (i_kind) begin
            w_load_mant = v_long[23:1];
        end else begin
            w_load_mant = {w_b1, w_b2, 7'b0000000};
        end
    end

    assign w_accept    = i_valid && o_ready;
    // A zero mantissa never normalizes; finish at once.
    assign w_norm_done = r_mant[MANT_W-1] || r_zero;
    assign w_out_free  = !r_out_valid || i_ready;
    assign w_exp_final = r_exp - 8'd1;
    assign w_packed    = r_zero ? 32'd0
                       : {r_sign, w_exp_final, r_mant[MANT_W-2:0], 1'b0};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM, ST_HOLD: begin
                if (w_norm_done) begin
                    n_state = w_out_free ? ST_IDLE : ST_HOLD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        o_ready     = 1'b0;
        w_write_out = 1'b0;
        n_mant      = r_mant;
        n_exp       = r_exp;
        n_sign      = r_sign;
        n_zero      = r_zero;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (w_accept) begin
                    // Load the shift register and the starting exponent
                    n_mant = w_load_mant;
                    n_exp  = C_EXP_OFFSET + {1'b0, w_b0[6:0]};
                    n_sign = w_b0[7];
                    n_zero = (w_load_mant == '0);
                end
            end
            ST_NORM, ST_HOLD: begin
                if (w_norm_done) begin
                    w_write_out = w_out_free;
                end else begin
                    // Advance one bit, one exponent step
                    n_mant = {r_mant[MANT_W-2:0], 1'b0};
                    n_exp  = r_exp - 8'd1;
                end
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // Output register: drop on take, load on a finished conversion
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_bits  = r_out_bits;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_write_out) begin
            n_out_valid = 1'b1;
            n_out_bits  = w_packed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mant     <= n_mant;
        r_exp      <= n_exp;
        r_sign     <= n_sign;
        r_zero     <= n_zero;
        r_out_bits <= n_out_bits;
    end

    assign o_valid     = r_out_valid;
    assign o_ieee_bits = r_out_bits;

`ifndef NO_ASSERTIONS
    // Each normalize shift takes exactly one off the exponent
    a_exp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NORM && !w_norm_done)
            |=> (r_exp == $past(r_exp) - 8'd1))
        else $error("exponent did not follow the normalize shift");

    // An accepted request always starts normalization
    a_accept_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_NORM))
        else $error("accepted request did not enter normalization");

    // A result only appears from a finished conversion
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == ST_NORM || $past(r_state) == ST_HOLD))
        else $error("result appeared without a conversion");

    // Never hold a finished conversion while the output is free
    a_hold_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD) |-> $past(r_out_valid) && !$past(i_ready))
        else $error("hold state entered with a free output");
`endif

endmodule

`default_nettype wire
